[rtl/core/pr3d_pkg.sv]
// pr3d_pkg: shared types and constants for the two-axis point rotation core
// holds the cordic word layout, the gain constant and the arctangent table
// no dependencies
`default_nettype none

package pr3d_pkg;

   localparam int TRIG_WIDTH   = 32;
   localparam int TRIG_FRAC    = 28;
   localparam int ATAN_ENTRIES = 24;

   localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = 32'sd163008219;

   localparam logic [TRIG_WIDTH-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // one angle in flight through the cordic chain
   typedef struct packed {
      logic                         flip;
      logic signed [TRIG_WIDTH-1:0] x;
      logic signed [TRIG_WIDTH-1:0] y;
      logic signed [TRIG_WIDTH-1:0] z;
   } trig_type;

endpackage

`default_nettype wire

[rtl/core/point_rotation_3d_two_axis.sv]
// point_rotation_3d_two_axis: rotates a point in the y-z plane and then in the x-z plane
// depends on pr3d_pkg, pr3d_cell, pr3d_rotate
//
//   channel | dir | word
//   req_    | in  | x_in, y_in, z_in, angle_xz, angle_yz
//   rsp_    | out | x_out, y_out, z_out
//
// one point per cycle while no output word waits untaken; the path is the cordic cell row,
// two product/round stages per rotation and the output register
// reset clears only the valid bits of the pipe
// the whole pipe holds while an output word waits and is not taken
`default_nettype none

module point_rotation_3d_two_axis #(
   parameter int COORD_WIDTH   = 24,
   parameter int ANGLE_WIDTH   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // x_in, y_in, z_in, angle_xz, angle_yz
   input  wire logic [((3*COORD_WIDTH+2*ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // x_out, y_out, z_out
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata
);
   import pr3d_pkg::*;

   localparam int OUT_BITS = ((3*COORD_WIDTH+7)/8)*8;
   localparam int DEPTH    = CORDIC_STAGES + 4;
   localparam int W1       = COORD_WIDTH + 2;
   localparam int W2       = COORD_WIDTH + 4;
   localparam logic signed [W2-1:0] SAT_MAX = W2'((64'sd1 <<< (COORD_WIDTH-1)) - 64'sd1);
   localparam logic signed [W2-1:0] SAT_MIN = -SAT_MAX - W2'(1);

   logic                          advance;
   logic [DEPTH-1:0]              vld_ff, vld_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [3*COORD_WIDTH-1:0]      rsp_data_ff, rsp_data_in;

   logic [ANGLE_WIDTH-1:0]        ang_xz, ang_yz;
   trig_type                      b_chain [CORDIC_STAGES+1];
   trig_type                      a_chain [CORDIC_STAGES+1];
   logic signed [COORD_WIDTH-1:0] x_chain [CORDIC_STAGES+1];
   logic signed [COORD_WIDTH-1:0] y_chain [CORDIC_STAGES+1];
   logic signed [COORD_WIDTH-1:0] z_chain [CORDIC_STAGES+1];

   logic signed [TRIG_WIDTH-1:0]  cb, sb, ca, sa;
   logic signed [COORD_WIDTH-1:0] xd_ff [2];
   logic signed [TRIG_WIDTH-1:0]  cad_ff [2];
   logic signed [TRIG_WIDTH-1:0]  sad_ff [2];
   logic signed [W1-1:0]          y1, z1;
   logic signed [W1-1:0]          y1d_ff [2];
   logic signed [W2-1:0]          x2, z2;

   function automatic trig_type seed(input logic [ANGLE_WIDTH-1:0] ang);
      trig_type              t;
      logic [TRIG_WIDTH-1:0] a;
      a      = {ang, {(TRIG_WIDTH-ANGLE_WIDTH){1'b0}}};
      t.flip = a[TRIG_WIDTH-1] ^ a[TRIG_WIDTH-2];
      t.x    = CORDIC_GAIN;
      t.y    = '0;
      t.z    = signed'({a[TRIG_WIDTH-1] ^ t.flip, a[TRIG_WIDTH-2:0]});
      return t;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [W2-1:0] v);
      logic signed [W2-1:0] r;
      priority if (v > SAT_MAX) begin
         r = SAT_MAX;
      end else if (v < SAT_MIN) begin
         r = SAT_MIN;
      end else begin
         r = v;
      end
      return r[COORD_WIDTH-1:0];
   endfunction

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   assign ang_xz = req_tdata[3*COORD_WIDTH+ANGLE_WIDTH-1:3*COORD_WIDTH];
   assign ang_yz = req_tdata[3*COORD_WIDTH+2*ANGLE_WIDTH-1:3*COORD_WIDTH+ANGLE_WIDTH];

   assign b_chain[0] = seed(ang_yz);
   assign a_chain[0] = seed(ang_xz);
   assign x_chain[0] = signed'(req_tdata[COORD_WIDTH-1:0]);
   assign y_chain[0] = signed'(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
   assign z_chain[0] = signed'(req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]);

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      pr3d_cell #(
         .COORD_WIDTH(COORD_WIDTH),
         .STAGE      (k)
      ) u_cell (
         .clock  (clock),
         .advance(advance),
         .b_in   (b_chain[k]),
         .a_in   (a_chain[k]),
         .x_in   (x_chain[k]),
         .y_in   (y_chain[k]),
         .z_in   (z_chain[k]),
         .b_out  (b_chain[k+1]),
         .a_out  (a_chain[k+1]),
         .x_out  (x_chain[k+1]),
         .y_out  (y_chain[k+1]),
         .z_out  (z_chain[k+1])
      );
   end

   // undo the quadrant fold
   always_comb begin
      cb = b_chain[CORDIC_STAGES].flip ? -b_chain[CORDIC_STAGES].x : b_chain[CORDIC_STAGES].x;
      sb = b_chain[CORDIC_STAGES].flip ? -b_chain[CORDIC_STAGES].y : b_chain[CORDIC_STAGES].y;
      ca = a_chain[CORDIC_STAGES].flip ? -a_chain[CORDIC_STAGES].x : a_chain[CORDIC_STAGES].x;
      sa = a_chain[CORDIC_STAGES].flip ? -a_chain[CORDIC_STAGES].y : a_chain[CORDIC_STAGES].y;
   end

   pr3d_rotate #(
      .IN_WIDTH(COORD_WIDTH)
   ) u_rot_yz (
      .clock  (clock),
      .advance(advance),
      .u_in   (y_chain[CORDIC_STAGES]),
      .v_in   (z_chain[CORDIC_STAGES]),
      .cos_in (cb),
      .sin_in (sb),
      .u_out  (y1),
      .v_out  (z1)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         xd_ff[0]  <= x_chain[CORDIC_STAGES];
         xd_ff[1]  <= xd_ff[0];
         cad_ff[0] <= ca;
         cad_ff[1] <= cad_ff[0];
         sad_ff[0] <= sa;
         sad_ff[1] <= sad_ff[0];
         y1d_ff[0] <= y1;
         y1d_ff[1] <= y1d_ff[0];
      end
   end

   pr3d_rotate #(
      .IN_WIDTH(W1)
   ) u_rot_xz (
      .clock  (clock),
      .advance(advance),
      .u_in   (W1'(xd_ff[1])),
      .v_in   (z1),
      .cos_in (cad_ff[1]),
      .sin_in (sad_ff[1]),
      .u_out  (x2),
      .v_out  (z2)
   );

   always_comb begin
      vld_in       = advance ? {vld_ff[DEPTH-2:0], req_tvalid} : vld_ff;
      rsp_valid_in = advance ? vld_ff[DEPTH-1] : rsp_valid_ff;
      rsp_data_in  = {sat(z2), sat(W2'(y1d_ff[1])), sat(x2)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_BITS'(rsp_data_ff);

endmodule

`default_nettype wire

[rtl/core/pr3d_cell.sv]
// pr3d_cell: one cordic micro-rotation for both angles, plus the point riding along
// depends on pr3d_pkg
`default_nettype none

module pr3d_cell #(
   parameter int COORD_WIDTH = 24,
   parameter int STAGE       = 0
) (
   input  wire logic                          clock,
   input  wire logic                          advance,
   input  wire pr3d_pkg::trig_type            b_in,
   input  wire pr3d_pkg::trig_type            a_in,
   input  wire logic signed [COORD_WIDTH-1:0] x_in,
   input  wire logic signed [COORD_WIDTH-1:0] y_in,
   input  wire logic signed [COORD_WIDTH-1:0] z_in,
   output pr3d_pkg::trig_type                 b_out,
   output pr3d_pkg::trig_type                 a_out,
   output logic signed [COORD_WIDTH-1:0]      x_out,
   output logic signed [COORD_WIDTH-1:0]      y_out,
   output logic signed [COORD_WIDTH-1:0]      z_out
);
   import pr3d_pkg::*;

   localparam logic signed [TRIG_WIDTH-1:0] ATAN_STEP = signed'(ATAN_TABLE[STAGE]);

   trig_type                       b_ff, b_in_w, a_ff, a_in_w;
   logic signed [COORD_WIDTH-1:0]  x_ff, y_ff, z_ff;

   function automatic trig_type step(input trig_type t);
      trig_type                     r;
      logic signed [TRIG_WIDTH-1:0] dx, dy;
      dx     = t.y >>> STAGE;
      dy     = t.x >>> STAGE;
      r.flip = t.flip;
      if (!t.z[TRIG_WIDTH-1]) begin
         r.x = t.x - dx;
         r.y = t.y + dy;
         r.z = t.z - ATAN_STEP;
      end else begin
         r.x = t.x + dx;
         r.y = t.y - dy;
         r.z = t.z + ATAN_STEP;
      end
      return r;
   endfunction

   always_comb begin
      b_in_w = step(b_in);
      a_in_w = step(a_in);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_ff <= b_in_w;
         a_ff <= a_in_w;
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign b_out = b_ff;
   assign a_out = a_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

`default_nettype wire

[rtl/core/pr3d_rotate.sv]
// pr3d_rotate: one plane rotation, products in the first stage, sum and rounding in the second
// depends on pr3d_pkg
`default_nettype none

module pr3d_rotate #(
   parameter int IN_WIDTH = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   advance,
   input  wire logic signed [IN_WIDTH-1:0]             u_in,
   input  wire logic signed [IN_WIDTH-1:0]             v_in,
   input  wire logic signed [pr3d_pkg::TRIG_WIDTH-1:0] cos_in,
   input  wire logic signed [pr3d_pkg::TRIG_WIDTH-1:0] sin_in,
   output logic signed [IN_WIDTH+1:0]                  u_out,
   output logic signed [IN_WIDTH+1:0]                  v_out
);
   import pr3d_pkg::*;

   localparam int PW = IN_WIDTH + TRIG_WIDTH;
   localparam logic signed [PW:0] ROUND_HALF = (PW+1)'(1) <<< (TRIG_FRAC - 1);

   logic signed [PW-1:0]       uc_ff, uc_in, vs_ff, vs_in, vc_ff, vc_in, us_ff, us_in;
   logic signed [PW:0]         su_w, sv_w, ru_w, rv_w;
   logic signed [IN_WIDTH+1:0] u_ff, u_in_w, v_ff, v_in_w;

   always_comb begin
      uc_in = PW'(u_in) * PW'(cos_in);
      vs_in = PW'(v_in) * PW'(sin_in);
      vc_in = PW'(v_in) * PW'(cos_in);
      us_in = PW'(u_in) * PW'(sin_in);
   end

   always_comb begin
      su_w   = (PW+1)'(uc_ff) + (PW+1)'(vs_ff) + ROUND_HALF;
      sv_w   = (PW+1)'(vc_ff) - (PW+1)'(us_ff) + ROUND_HALF;
      ru_w   = su_w >>> TRIG_FRAC;
      rv_w   = sv_w >>> TRIG_FRAC;
      u_in_w = ru_w[IN_WIDTH+1:0];
      v_in_w = rv_w[IN_WIDTH+1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         uc_ff <= uc_in;
         vs_ff <= vs_in;
         vc_ff <= vc_in;
         us_ff <= us_in;
         u_ff  <= u_in_w;
         v_ff  <= v_in_w;
      end
   end

   assign u_out = u_ff;
   assign v_out = v_ff;

endmodule

`default_nettype wire
